@@ src/hhfe_pkg.sv @@
// ----------------------------------------------------------------------------
// hhfe_pkg
// Shared types, constants and helpers for the HTTP header field extractor.
// ----------------------------------------------------------------------------
package hhfe_pkg;

  localparam int MAX_NAME = 16;

  localparam int NAME_POS_W   = 5;
  localparam int STATUS_POS_W = 4;
  localparam int CODE_W       = 10;
  localparam int NUM_W        = 32;
  localparam int APB_ADDR_W   = 5;
  localparam int APB_DATA_W   = 64;

  localparam logic [NAME_POS_W-1:0] NAME_MAX = NAME_POS_W'(MAX_NAME);

  // status line layout: "http/1.x " then three digits
  localparam logic [STATUS_POS_W-1:0] PREFIX_LEN = 4'd9;
  localparam logic [STATUS_POS_W-1:0] MINOR_POS  = 4'd7;
  localparam logic [STATUS_POS_W-1:0] HUND_POS   = 4'd9;
  localparam logic [STATUS_POS_W-1:0] TENS_POS   = 4'd10;
  localparam logic [STATUS_POS_W-1:0] STATUS_END = 4'd12;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3a;

  // register indexes, byte address = 8 * index
  localparam logic [1:0] REG_NAME_LO  = 2'd0;
  localparam logic [1:0] REG_NAME_HI  = 2'd1;
  localparam logic [1:0] REG_NAME_LEN = 2'd2;

  localparam logic [NAME_POS_W-1:0] NAME_LEN_RST = 5'd14;

  typedef enum logic [2:0] {
    PH_STATUS,
    PH_SKIP,
    PH_NAME,
    PH_LEAD,
    PH_VALUE,
    PH_DRAIN
  } phase_t;

  typedef struct packed {
    logic [63:0]           name_lo;
    logic [63:0]           name_hi;
    logic [NAME_POS_W-1:0] name_len;
  } search_cfg_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = ((c >= 8'h41) && (c <= 8'h5a)) ? c + 8'd32 : c;
    return r;
  endfunction

  function automatic logic [7:0] prefix_char(input logic [STATUS_POS_W-1:0] pos);
    logic [7:0] r;
    unique case (pos)
      4'd0:    r = 8'h68;  // h
      4'd1:    r = 8'h74;  // t
      4'd2:    r = 8'h74;  // t
      4'd3:    r = 8'h70;  // p
      4'd4:    r = 8'h2f;  // /
      4'd5:    r = 8'h31;  // 1
      4'd6:    r = 8'h2e;  // .
      4'd7:    r = 8'h78;  // minor digit, not compared
      4'd8:    r = 8'h20;  // space
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

@@ src/hhfe_in_if.sv @@
// ----------------------------------------------------------------------------
// hhfe_in_if
// Header byte channel: valid/ready with one header byte per beat.
// ----------------------------------------------------------------------------
interface hhfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] hdr_byte;
  logic       first_byte;

  modport source (output valid, output hdr_byte, output first_byte, input ready);
  modport sink   (input valid, input hdr_byte, input first_byte, output ready);
endinterface

@@ src/hhfe_out_if.sv @@
// ----------------------------------------------------------------------------
// hhfe_out_if
// Result channel: value bytes and the final summary beat.
// ----------------------------------------------------------------------------
interface hhfe_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  value_byte;
  logic        is_last;
  logic        found;
  logic        status_valid;
  logic [9:0]  status_code;
  logic [31:0] number_value;

  modport source (output valid, output value_byte, output is_last, output found,
                  output status_valid, output status_code, output number_value,
                  input ready);
  modport sink   (input valid, input value_byte, input is_last, input found,
                  input status_valid, input status_code, input number_value,
                  output ready);
endinterface

@@ src/hhfe_cfg.sv @@
// ----------------------------------------------------------------------------
// hhfe_cfg
// APB register block holding the wanted field name and its length.
// ----------------------------------------------------------------------------
module hhfe_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hhfe_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [hhfe_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [hhfe_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  output hhfe_pkg::search_cfg_t            cfg
);

  hhfe_pkg::search_cfg_t regs;
  logic                  wr_en;
  logic [1:0]            reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.name_lo  <= '0;
      regs.name_hi  <= '0;
      regs.name_len <= hhfe_pkg::NAME_LEN_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        hhfe_pkg::REG_NAME_LO:  regs.name_lo  <= pwdata;
        hhfe_pkg::REG_NAME_HI:  regs.name_hi  <= pwdata;
        hhfe_pkg::REG_NAME_LEN: regs.name_len <= pwdata[hhfe_pkg::NAME_POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      hhfe_pkg::REG_NAME_LO:  prdata = regs.name_lo;
      hhfe_pkg::REG_NAME_HI:  prdata = regs.name_hi;
      hhfe_pkg::REG_NAME_LEN: prdata = {{(hhfe_pkg::APB_DATA_W-hhfe_pkg::NAME_POS_W){1'b0}},
                                        regs.name_len};
      default:                prdata = '0;
    endcase
  end

endmodule

@@ src/http_header_field_extractor_top.sv @@
// A result beat is registered and presented in the cycle after the header beat that causes it.
// Throughput: one header beat per cycle while no result beat waits; the parse step is a single pass of
//   compares and two multiply-adds between the state and result registers.
// A result beat left waiting on res_out.ready holds off header beats until it is taken.
// rst (synchronous, active high) clears the parse state, the result valid flag and
//   the name registers (length back to 14).
// ----------------------------------------------------------------------------
// http_header_field_extractor_top
// Parses an HTTP response header byte stream, checks the status line and
// streams out the value of one configured header field.
// ----------------------------------------------------------------------------
module http_header_field_extractor_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hhfe_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [hhfe_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [hhfe_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready,
  hhfe_in_if.sink                          hdr_in,
  hhfe_out_if.source                       res_out
);

  hhfe_pkg::search_cfg_t cfg;

  hhfe_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // parse state
  hhfe_pkg::phase_t                     phase, phase_next;
  logic [hhfe_pkg::STATUS_POS_W-1:0]    status_pos, status_pos_next;
  logic                                 status_prefix_ok, status_prefix_ok_next;
  logic [hhfe_pkg::CODE_W-1:0]          code_accum, code_accum_next;
  logic                                 code_digits_ok, code_digits_ok_next;
  logic [hhfe_pkg::NAME_POS_W-1:0]      name_pos, name_pos_next;
  logic                                 name_match, name_match_next;
  logic [hhfe_pkg::NUM_W-1:0]           value_accum, value_accum_next;
  logic                                 finished, finished_next;

  // step results
  logic                                 emit, emit_last, emit_found;
  logic [7:0]                           emit_byte;
  logic                                 stat_ok;

  // result register
  logic                                 out_valid;
  logic [7:0]                           out_value_byte;
  logic                                 out_is_last;
  logic                                 out_found;
  logic                                 out_status_valid;
  logic [hhfe_pkg::CODE_W-1:0]          out_status_code;
  logic [hhfe_pkg::NUM_W-1:0]           out_number_value;

  logic                                 in_fire;

  assign hdr_in.ready = !out_valid || res_out.ready;
  assign in_fire      = hdr_in.valid && hdr_in.ready;

  always_comb begin
    logic [7:0]                        b;
    logic [3:0]                        digit;
    logic [6:0]                        wgt;
    logic [10:0]                       code_sum;
    logic [63:0]                       wword;
    logic [7:0]                        wchar;
    logic [hhfe_pkg::NUM_W-1:0]        vterm;

    b     = hdr_in.hdr_byte;
    digit = b[3:0] - hhfe_pkg::CH_ZERO[3:0];

    if (hdr_in.first_byte) begin
      phase_next            = hhfe_pkg::PH_STATUS;
      status_pos_next       = '0;
      status_prefix_ok_next = 1'b1;
      code_accum_next       = '0;
      code_digits_ok_next   = 1'b1;
      name_pos_next         = '0;
      name_match_next       = 1'b1;
      value_accum_next      = '0;
      finished_next         = 1'b0;
    end else begin
      phase_next            = phase;
      status_pos_next       = status_pos;
      status_prefix_ok_next = status_prefix_ok;
      code_accum_next       = code_accum;
      code_digits_ok_next   = code_digits_ok;
      name_pos_next         = name_pos;
      name_match_next       = name_match;
      value_accum_next      = value_accum;
      finished_next         = finished;
    end

    // weight depends on the position after the first-byte clear
    wgt   = (status_pos_next == hhfe_pkg::HUND_POS) ? 7'd100 :
            (status_pos_next == hhfe_pkg::TENS_POS) ? 7'd10 : 7'd1;
    code_sum = 11'(code_accum_next) + 11'(digit) * 11'(wgt);

    wword = name_pos_next[3] ? cfg.name_hi : cfg.name_lo;
    wchar = hhfe_pkg::to_lower(wword[{name_pos_next[2:0], 3'b000} +: 8]);
    vterm = 32'(value_accum_next * 32'd10) + ({24'd0, b} - {24'd0, hhfe_pkg::CH_ZERO});

    emit       = 1'b0;
    emit_last  = 1'b0;
    emit_found = 1'b0;
    emit_byte  = '0;

    if (!finished_next) begin
      if (b == hhfe_pkg::CH_NUL) begin
        emit       = 1'b1;
        emit_last  = 1'b1;
        emit_found = ((phase_next == hhfe_pkg::PH_LEAD) ||
                      (phase_next == hhfe_pkg::PH_VALUE)) && name_match_next;
      end else begin
        unique case (phase_next)
          hhfe_pkg::PH_STATUS: begin
            if (b == hhfe_pkg::CH_CR) begin
              if (status_pos_next < hhfe_pkg::PREFIX_LEN) status_prefix_ok_next = 1'b0;
              if (status_pos_next < hhfe_pkg::STATUS_END) code_digits_ok_next = 1'b0;
              phase_next = hhfe_pkg::PH_SKIP;
            end else if (status_pos_next < hhfe_pkg::PREFIX_LEN) begin
              if ((status_pos_next != hhfe_pkg::MINOR_POS) &&
                  (hhfe_pkg::to_lower(b) != hhfe_pkg::prefix_char(status_pos_next)))
                status_prefix_ok_next = 1'b0;
              status_pos_next = status_pos_next + 4'd1;
            end else if (status_pos_next < hhfe_pkg::STATUS_END) begin
              if ((b >= hhfe_pkg::CH_ZERO) && (b <= hhfe_pkg::CH_NINE))
                code_accum_next = code_sum[hhfe_pkg::CODE_W-1:0];
              else
                code_digits_ok_next = 1'b0;
              status_pos_next = status_pos_next + 4'd1;
            end
          end
          hhfe_pkg::PH_SKIP: begin
            phase_next = status_prefix_ok_next ? hhfe_pkg::PH_NAME : hhfe_pkg::PH_DRAIN;
          end
          hhfe_pkg::PH_NAME: begin
            if (b == hhfe_pkg::CH_COLON) begin
              name_match_next = name_match_next && (name_pos_next == cfg.name_len) &&
                                (cfg.name_len <= hhfe_pkg::NAME_MAX);
              value_accum_next = '0;
              phase_next       = hhfe_pkg::PH_LEAD;
            end else begin
              if ((name_pos_next < cfg.name_len) && (name_pos_next < hhfe_pkg::NAME_MAX)) begin
                if (hhfe_pkg::to_lower(b) != wchar) name_match_next = 1'b0;
              end else begin
                name_match_next = 1'b0;
              end
              if (name_pos_next <= hhfe_pkg::NAME_MAX) name_pos_next = name_pos_next + 5'd1;
            end
          end
          hhfe_pkg::PH_LEAD, hhfe_pkg::PH_VALUE: begin
            if (b == hhfe_pkg::CH_CR) begin
              if (name_match_next) begin
                emit       = 1'b1;
                emit_last  = 1'b1;
                emit_found = 1'b1;
              end
            end else if (b == hhfe_pkg::CH_LF) begin
              phase_next      = hhfe_pkg::PH_NAME;
              name_pos_next   = '0;
              name_match_next = 1'b1;
            end else begin
              if ((phase_next == hhfe_pkg::PH_LEAD) && (b != hhfe_pkg::CH_SP))
                phase_next = hhfe_pkg::PH_VALUE;
              if ((phase_next == hhfe_pkg::PH_VALUE) && name_match_next) begin
                value_accum_next = vterm;
                emit             = 1'b1;
                emit_byte        = b;
              end
            end
          end
          default: ;
        endcase
      end
      if (emit && emit_last) finished_next = 1'b1;
    end

    stat_ok = status_prefix_ok_next && code_digits_ok_next &&
              (status_pos_next >= hhfe_pkg::STATUS_END);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= hhfe_pkg::PH_STATUS;
      status_pos       <= '0;
      status_prefix_ok <= 1'b1;
      code_accum       <= '0;
      code_digits_ok   <= 1'b1;
      name_pos         <= '0;
      name_match       <= 1'b1;
      value_accum      <= '0;
      finished         <= 1'b0;
    end else if (in_fire) begin
      phase            <= phase_next;
      status_pos       <= status_pos_next;
      status_prefix_ok <= status_prefix_ok_next;
      code_accum       <= code_accum_next;
      code_digits_ok   <= code_digits_ok_next;
      name_pos         <= name_pos_next;
      name_match       <= name_match_next;
      value_accum      <= value_accum_next;
      finished         <= finished_next;
    end
  end

  // result register: loads on a beat that emits, drains on the output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid <= 1'b1;
    end else if (res_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_value_byte   <= emit_byte;
      out_is_last      <= emit_last;
      out_found        <= emit_found;
      out_status_valid <= emit_last && stat_ok;
      out_status_code  <= (emit_last && stat_ok) ? code_accum_next : '0;
      out_number_value <= (emit_last && emit_found) ? value_accum_next : '0;
    end
  end

  assign res_out.valid        = out_valid;
  assign res_out.value_byte   = out_value_byte;
  assign res_out.is_last      = out_is_last;
  assign res_out.found        = out_found;
  assign res_out.status_valid = out_status_valid;
  assign res_out.status_code  = out_status_code;
  assign res_out.number_value = out_number_value;

endmodule

@@ tb/hhfe_field_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hhfe_field_checker
// Follows the register port and both beat channels of the header field
// extractor, keeps its own copy of the parse state and name registers,
// predicts every result beat and compares it with the beat that comes out.
// ----------------------------------------------------------------------------
module hhfe_field_checker
  import hhfe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  hhfe_in_if                    hdr_mon,
  hhfe_out_if                   res_mon,
  output int                    mismatches,
  output int                    outstanding,
  output int                    headers_seen,
  output int                    value_beats,
  output int                    final_beats,
  output int                    found_beats
);

  typedef struct packed {
    logic [7:0]  value_byte;
    logic        is_last;
    logic        found;
    logic        status_valid;
    logic [9:0]  status_code;
    logic [31:0] number_value;
  } field_result_t;

  // lower-case status prefix, first character in the top byte
  localparam logic [71:0] HTTP_PREFIX = "http/1.x ";

  logic [63:0]           want_lo;
  logic [63:0]           want_hi;
  logic [NAME_POS_W-1:0] want_len;

  phase_t                  ph;
  logic [STATUS_POS_W-1:0] st_pos;
  logic                    pfx_ok;
  logic [CODE_W-1:0]       code;
  logic                    digits_ok;
  logic [NAME_POS_W-1:0]   nm_pos;
  logic                    nm_match;
  logic [NUM_W-1:0]        num;
  logic                    done;

  field_result_t expected_q[$];

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
  endfunction

  function automatic logic [7:0] wanted_char(input logic [NAME_POS_W-1:0] p);
    logic [63:0] w;
    w = (p < 5'd8) ? want_lo : want_hi;
    return fold_case(w[{p[2:0], 3'b000} +: 8]);
  endfunction

  task automatic clear_parse();
    ph        = PH_STATUS;
    st_pos    = '0;
    pfx_ok    = 1'b1;
    code      = '0;
    digits_ok = 1'b1;
    nm_pos    = '0;
    nm_match  = 1'b1;
    num       = '0;
    done      = 1'b0;
  endtask

  task automatic push_result(input logic [7:0] vb, input logic last, input logic fnd);
    field_result_t r;
    logic          sv;
    sv             = pfx_ok && digits_ok && (st_pos >= STATUS_END);
    r.value_byte   = vb;
    r.is_last      = last;
    r.found        = fnd;
    r.status_valid = last && sv;
    r.status_code  = (last && sv) ? code : '0;
    r.number_value = (last && fnd) ? num : '0;
    expected_q.push_back(r);
    if (last) done = 1'b1;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic first);
    logic [CODE_W-1:0] wgt;
    if (first) clear_parse();
    if (done) return;
    if (b == CH_NUL) begin
      push_result(8'h00, 1'b1, (ph == PH_LEAD || ph == PH_VALUE) && nm_match);
      return;
    end
    case (ph)
      PH_STATUS: begin
        if (b == CH_CR) begin
          if (st_pos < PREFIX_LEN) pfx_ok = 1'b0;
          if (st_pos < STATUS_END) digits_ok = 1'b0;
          ph = PH_SKIP;
        end else if (st_pos < PREFIX_LEN) begin
          if (st_pos != MINOR_POS &&
              fold_case(b) != HTTP_PREFIX[8*(8-int'(st_pos)) +: 8]) pfx_ok = 1'b0;
          st_pos++;
        end else if (st_pos < STATUS_END) begin
          if (b >= CH_ZERO && b <= CH_NINE) begin
            wgt  = (st_pos == HUND_POS) ? 10'd100 : (st_pos == TENS_POS) ? 10'd10 : 10'd1;
            code = code + 10'(b - CH_ZERO) * wgt;
          end else begin
            digits_ok = 1'b0;
          end
          st_pos++;
        end
      end
      // the byte after the status line's CR is dropped unless it is NUL, which ends the header
      PH_SKIP: ph = pfx_ok ? PH_NAME : PH_DRAIN;
      PH_NAME: begin
        if (b == CH_COLON) begin
          nm_match = nm_match && (nm_pos == want_len) && (want_len <= NAME_MAX);
          num      = '0;
          ph       = PH_LEAD;
        end else begin
          if (nm_pos < want_len && nm_pos < NAME_MAX) begin
            if (fold_case(b) != wanted_char(nm_pos)) nm_match = 1'b0;
          end else begin
            nm_match = 1'b0;
          end
          if (nm_pos <= NAME_MAX) nm_pos++;
        end
      end
      PH_LEAD, PH_VALUE: begin
        if (b == CH_CR) begin
          if (nm_match) push_result(8'h00, 1'b1, 1'b1);
        end else if (b == CH_LF) begin
          ph       = PH_NAME;
          nm_pos   = '0;
          nm_match = 1'b1;
        end else begin
          if (ph == PH_LEAD && b != CH_SP) ph = PH_VALUE;
          if (ph == PH_VALUE && nm_match) begin
            num = num * 32'd10 + {24'd0, b} - 32'd48;
            push_result(b, 1'b0, 1'b0);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_beat();
    field_result_t got;
    field_result_t exp_r;
    got = '{res_mon.value_byte, res_mon.is_last, res_mon.found, res_mon.status_valid,
            res_mon.status_code, res_mon.number_value};
    if (got.is_last) begin
      final_beats++;
      if (got.found) found_beats++;
    end else begin
      value_beats++;
    end
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result beat with none pending: byte %02h last %0b found %0b",
                 $realtime, got.value_byte, got.is_last, got.found);
      return;
    end
    exp_r = expected_q.pop_front();
    if (got.value_byte !== exp_r.value_byte || got.is_last !== exp_r.is_last ||
        got.found !== exp_r.found || got.status_valid !== exp_r.status_valid ||
        got.status_code !== exp_r.status_code || got.number_value !== exp_r.number_value)
    begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: result mismatch", $realtime);
        $display("  expected byte %02h last %0b found %0b status %0b code %0d number %0d",
                 exp_r.value_byte, exp_r.is_last, exp_r.found, exp_r.status_valid,
                 exp_r.status_code, exp_r.number_value);
        $display("  actual   byte %02h last %0b found %0b status %0b code %0d number %0d",
                 got.value_byte, got.is_last, got.found, got.status_valid,
                 got.status_code, got.number_value);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      want_lo  = '0;
      want_hi  = '0;
      want_len = NAME_LEN_RST;
      clear_parse();
      expected_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_ADDR_W-1:3])
          REG_NAME_LO:  want_lo  = pwdata;
          REG_NAME_HI:  want_hi  = pwdata;
          REG_NAME_LEN: want_len = pwdata[NAME_POS_W-1:0];
          default: ;
        endcase
      end
      // results at this edge come from earlier header beats
      if (res_mon.valid && res_mon.ready) check_beat();
      if (hdr_mon.valid && hdr_mon.ready) begin
        if (hdr_mon.first_byte) headers_seen++;
        parse_byte(hdr_mon.hdr_byte, hdr_mon.first_byte);
      end
    end
    outstanding = expected_q.size();
  end

endmodule

@@ tb/tb_http_header_field_extractor_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_http_header_field_extractor_top
// Sends directed and random HTTP response headers through the field
// extractor under several wanted-name settings, with random gaps and stalls
// on both channels; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_http_header_field_extractor_top;
  import hhfe_pkg::*;

  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_BEATS = 1050;
  localparam int N_SETTINGS   = 7;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  hhfe_in_if  hdr_bus ();
  hhfe_out_if res_bus ();

  int mismatch_cnt;
  int outstanding;
  int headers_seen;
  int value_beats;
  int final_beats;
  int found_beats;

  bit          no_idle = 1'b0;
  int          src_calm = 0;
  int          beats_sent = 0;
  logic [7:0]  hdr_q[$];
  logic [63:0] want_lo;
  logic [63:0] want_hi;
  int          want_len;

  http_header_field_extractor_top dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .hdr_in  (hdr_bus),
    .res_out (res_bus)
  );

  hhfe_field_checker field_chk (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .hdr_mon      (hdr_bus),
    .res_mon      (res_bus),
    .mismatches   (mismatch_cnt),
    .outstanding  (outstanding),
    .headers_seen (headers_seen),
    .value_beats  (value_beats),
    .final_beats  (final_beats),
    .found_beats  (found_beats)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("run stopped at the cycle limit of %0d", CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // result side: random stall bursts, with calm stretches between
  initial begin : result_sink
    int stall;
    int calm;
    stall = 0;
    calm  = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        res_bus.ready <= 1'b0;
        stall--;
      end else if (calm > 0 || no_idle) begin
        res_bus.ready <= 1'b1;
        if (calm > 0) calm--;
      end else begin
        case ($urandom_range(0, 15))
          0, 1, 2: begin
            res_bus.ready <= 1'b0;
            stall = $urandom_range(0, 5);
          end
          3: begin
            res_bus.ready <= 1'b1;
            calm = $urandom_range(20, 80);
          end
          default: res_bus.ready <= 1'b1;
        endcase
      end
    end
  end

  function automatic logic [7:0] rand_case(input logic [7:0] c);
    logic [7:0] l;
    l = (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
    if (l >= 8'h61 && l <= 8'h7a && $urandom_range(0, 1) == 1) l = l - 8'd32;
    return l;
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(32, 126)); while (c == CH_COLON);
    return c;
  endfunction

  function automatic logic [7:0] name_char(input int i);
    return (i < 8) ? want_lo[8*i +: 8] : want_hi[8*(i-8) +: 8];
  endfunction

  task automatic push_byte(input logic [7:0] b);
    hdr_q.push_back(b);
  endtask

  task automatic push_text(input string s);
    for (int k = 0; k < s.len(); k++) hdr_q.push_back(s[k]);
  endtask

  task automatic push_crlf();
    hdr_q.push_back(CH_CR);
    hdr_q.push_back(CH_LF);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({idx, 3'b000});
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_name(input logic [63:0] lo, input logic [63:0] hi, input int len);
    want_lo  = lo;
    want_hi  = hi;
    want_len = len;
    write_reg(REG_NAME_LO, lo);
    write_reg(REG_NAME_HI, hi);
    write_reg(REG_NAME_LEN, 64'(len));
  endtask

  task automatic pack_name(input string s, output logic [63:0] lo, output logic [63:0] hi);
    lo = '0;
    hi = '0;
    for (int k = 0; k < s.len(); k++) begin
      if (k < 8) lo[8*k +: 8] = s[k];
      else       hi[8*(k-8) +: 8] = s[k];
    end
  endtask

  task automatic send_beat(input logic [7:0] b, input logic first);
    int gap;
    if (src_calm > 0) begin
      src_calm--;
    end else if (!no_idle) begin
      case ($urandom_range(0, 39))
        0, 1, 2, 3, 4, 5: begin
          gap = $urandom_range(1, 6);
          repeat (gap) begin
            @(negedge clk);
            hdr_bus.valid <= 1'b0;
          end
        end
        6: src_calm = $urandom_range(20, 80);
        default: ;
      endcase
    end
    @(negedge clk);
    hdr_bus.valid      <= 1'b1;
    hdr_bus.hdr_byte   <= b;
    hdr_bus.first_byte <= first;
    @(posedge clk);
    while (!hdr_bus.ready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_header();
    for (int k = 0; k < hdr_q.size(); k++) send_beat(hdr_q[k], k == 0);
    hdr_q = {};
  endtask

  // block quiet: channel idle and every predicted beat out
  task automatic wait_drained();
    @(negedge clk);
    hdr_bus.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic push_field_name();
    int n;
    int pos;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: for (int i = 0; i < want_len; i++) push_byte(rand_case(name_char(i)));
      4: begin
        pos = $urandom_range(0, want_len - 1);
        for (int i = 0; i < want_len; i++)
          push_byte(i == pos ? 8'($urandom_range(1, 255)) : rand_case(name_char(i)));
      end
      5: begin
        n = ($urandom_range(0, 1) == 1) ? want_len + 1 : want_len - 1;
        for (int i = 0; i < n; i++) push_byte(i < want_len ? name_char(i) : text_byte());
      end
      6: begin
        n = $urandom_range(17, 22);
        repeat (n) push_byte(text_byte());
      end
      default: begin
        n = $urandom_range(1, 12);
        repeat (n) push_byte(text_byte());
      end
    endcase
  endtask

  task automatic make_header();
    string pre;
    int    n;
    pre = "http/1.";
    if ($urandom_range(0, 9) != 0) begin
      for (int k = 0; k < pre.len(); k++) push_byte(rand_case(pre[k]));
      push_byte($urandom_range(0, 3) == 0 ? 8'($urandom_range(1, 255))
                                          : 8'($urandom_range(48, 57)));
      push_byte($urandom_range(0, 19) == 0 ? text_byte() : CH_SP);
      repeat (3)
        push_byte($urandom_range(0, 9) == 0 ? text_byte() : 8'($urandom_range(48, 57)));
      n = $urandom_range(0, 6);
      repeat (n) push_byte(text_byte());
    end else begin
      n = $urandom_range(0, 14);
      repeat (n) push_byte(8'($urandom_range(1, 255)));
    end
    push_crlf();
    n = $urandom_range(0, 4);
    repeat (n) begin
      push_field_name();
      if ($urandom_range(0, 19) != 0) push_byte(CH_COLON);
      repeat ($urandom_range(0, 3)) push_byte(CH_SP);
      case ($urandom_range(0, 3))
        0, 1: repeat ($urandom_range(0, 12)) push_byte(8'($urandom_range(48, 57)));
        2:    repeat ($urandom_range(0, 6)) push_byte(text_byte());
        default: repeat ($urandom_range(0, 4)) push_byte(8'($urandom_range(1, 255)));
      endcase
      case ($urandom_range(0, 9))
        0:       ;
        1:       push_byte(CH_LF);
        default: push_crlf();
      endcase
    end
    if ($urandom_range(0, 4) < 3) push_crlf();
    // most headers end on NUL; some are cut short, some carry bytes after the end
    case ($urandom_range(0, 9))
      0, 1: ;
      2: begin
        push_byte(CH_NUL);
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(0, 255)));
      end
      default: push_byte(CH_NUL);
    endcase
  endtask

  initial begin : stimulus
    logic [63:0] lo;
    logic [63:0] hi;
    int          budget;

    rst                = 1'b1;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    hdr_bus.valid      = 1'b0;
    hdr_bus.hdr_byte   = '0;
    hdr_bus.first_byte = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset name registers: NUL as the very first byte, status too short
    push_byte(CH_NUL);
    send_header();
    wait_drained();

    pack_name("x", lo, hi);
    program_name(lo, hi, 1);
    // matched line ended by CR, leading spaces dropped, byte after the end ignored
    push_text("HTTP/1.1 200");
    push_crlf();
    push_text("X:  12");
    push_byte(CH_CR);
    push_text("Z");
    send_header();
    // bad prefix and short status line: only the NUL gives a result
    push_text("f");
    push_crlf();
    push_text("x:7");
    push_byte(CH_NUL);
    send_header();
    // bad code digit, a line with no colon runs into the next one
    push_text("http/1.9 5");
    push_byte(8'hff);
    push_crlf();
    push_text("ab");
    push_crlf();
    push_text("x:1");
    push_byte(CH_NUL);
    send_header();
    // NUL inside the matched value
    push_text("HTTP/1.0 999");
    push_crlf();
    push_text("x:9");
    push_byte(CH_NUL);
    send_header();

    for (int s = 0; s < N_SETTINGS; s++) begin
      wait_drained();
      case (s)
        0: begin
          pack_name("content-length", lo, hi);
          program_name(lo, hi, 14);
        end
        1: begin
          pack_name("X-Request-Id-ABC", lo, hi);
          program_name(lo, hi, 16);
        end
        2: program_name('1, '1, 16);
        3: program_name('0, '0, 1);
        4: program_name({$urandom, $urandom}, {$urandom, $urandom}, $urandom_range(1, 16));
        5: begin
          pack_name("Host", lo, hi);
          program_name({$urandom, lo[31:0]}, {$urandom, $urandom}, 4);
        end
        default: begin
          pack_name("content-length", lo, hi);
          program_name(lo, hi, 14);
          no_idle = 1'b1;
        end
      endcase
      budget = beats_sent + RANDOM_BEATS / N_SETTINGS;
      while (beats_sent < budget) begin
        make_header();
        send_header();
      end
    end

    wait_drained();
    $display("covered %0d header beats in %0d headers across %0d name settings",
             beats_sent, headers_seen, N_SETTINGS + 2);
    $display("checked %0d value beats and %0d final beats, %0d of them with the field",
             value_beats, final_beats, found_beats);
    if (mismatch_cnt == 0 && outstanding == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results never arrived", mismatch_cnt, outstanding);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ http_header_field_extractor_top.f @@
src/hhfe_pkg.sv
src/hhfe_in_if.sv
src/hhfe_out_if.sv
src/hhfe_cfg.sv
src/http_header_field_extractor_top.sv
tb/hhfe_field_checker.sv
tb/tb_http_header_field_extractor_top.sv
